// File: sv/drbd_pkg.sv
// Shared types, constants and helper functions for the detection row box decoder.
// Used by drbd_front, drbd_queue, drbd_back and detection_row_box_decode_top.
`timescale 1ns / 1ps

package drbd_pkg;

	localparam int VAL_W           = 16;
	localparam int POS_W           = 7;
	localparam int CLS_W           = 7;
	localparam int IMG_W           = 13;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 20;
	localparam int INV_W           = 20;
	localparam int PAD_W           = 10;
	localparam int OBJ_POS         = 4;
	localparam int FIRST_CLASS_POS = 5;
	localparam int BOX_SLOTS       = 4;
	localparam int POS_MAX         = 127;
	localparam int IMG_MAX         = 4096;
	localparam int Q_DEPTH         = 2;
	localparam int OUT_TDATA_W     = 80;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THRESHOLD = 3'd0,
		CFG_INV_SCALE = 3'd1,
		CFG_PAD_LEFT  = 3'd2,
		CFG_PAD_TOP   = 3'd3,
		CFG_IMG_W     = 3'd4,
		CFG_IMG_H     = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [VAL_W-1:0] threshold;
		logic [INV_W-1:0] inv_scale;
		logic [PAD_W-1:0] pad_left;
		logic [PAD_W-1:0] pad_top;
		logic [IMG_W-1:0] img_w;
		logic [IMG_W-1:0] img_h;
	} cfg_t;

	// one finished row handed from front to back
	typedef struct packed {
		logic [VAL_W-1:0] cx;
		logic [VAL_W-1:0] cy;
		logic [VAL_W-1:0] w;
		logic [VAL_W-1:0] h;
		logic [VAL_W-1:0] obj;
		logic [VAL_W-1:0] best;
		logic [CLS_W-1:0] cls;
	} job_t;

	// result layout, first field in the highest bits
	typedef struct packed {
		logic [VAL_W-1:0] score;
		logic [CLS_W-1:0] cls;
		logic [12:0]      height;
		logic [12:0]      width;
		logic [11:0]      top;
		logic [11:0]      left;
	} result_t;

	typedef struct packed {
		logic [12:0] ext;
		logic [11:0] pos;
	} axis_t;

	// zero reads as one, anything above the maximum reads as the maximum
	function automatic logic [IMG_W-1:0] dim_of(input logic [IMG_W-1:0] d);
		logic [IMG_W-1:0] r;
		r = d;
		if (d == '0)
			r = IMG_W'(1);
		else if (d > IMG_W'(IMG_MAX))
			r = IMG_W'(IMG_MAX);
		return r;
	endfunction

	// pos and ext are saturated to 13 bits; lim is 1..4096
	function automatic axis_t clamp_axis(input logic [12:0] pos, input logic [12:0] ext,
		input logic [12:0] lim);
		logic signed [14:0] sp;
		logic signed [14:0] se;
		logic signed [14:0] sl;
		logic signed [14:0] w1;
		logic signed [14:0] p;
		logic signed [14:0] room;
		axis_t r;
		sp = $signed({2'b00, pos});
		se = $signed({2'b00, ext});
		sl = $signed({2'b00, lim});
		w1 = (se < sl - sp) ? se : sl - sp;
		p = (sp < sl - 15'sd1) ? sp : sl - 15'sd1;
		if (w1 < 15'sd0)
			w1 = 15'sd0;
		room = sl - p;
		if (w1 > room)
			w1 = room;
		r.pos = p[11:0];
		r.ext = w1[12:0];
		return r;
	endfunction

endpackage

// File: sv/drbd_front.sv
// Front end: accepts row values, files box fields and objectness, tracks the best class.
// Hands each finished row to the queue. Depends on drbd_pkg.
`timescale 1ns / 1ps

module drbd_front #(
	parameter int NUM_CLASSES = 80
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [drbd_pkg::VAL_W-1:0] row_value,
	input  logic                      row_end,
	input  logic                      q_full,
	output logic                      push,
	output drbd_pkg::job_t            job
);

	localparam logic [7:0] CLS_END = 8'(drbd_pkg::FIRST_CLASS_POS + NUM_CLASSES);

	logic [drbd_pkg::POS_W-1:0] pos_q;
	logic [drbd_pkg::VAL_W-1:0] box_q [drbd_pkg::BOX_SLOTS];
	logic [drbd_pkg::VAL_W-1:0] obj_q;
	logic [drbd_pkg::VAL_W-1:0] best_q;
	logic [drbd_pkg::CLS_W-1:0] cls_q;

	logic [drbd_pkg::VAL_W-1:0] nbox [drbd_pkg::BOX_SLOTS];
	logic [drbd_pkg::VAL_W-1:0] nobj;
	logic [drbd_pkg::VAL_W-1:0] nbest;
	logic [drbd_pkg::CLS_W-1:0] ncls;
	logic                       accept;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign push     = accept && row_end;

	// state as it stands after the current value is taken
	always_comb begin
		nbox  = box_q;
		nobj  = obj_q;
		nbest = best_q;
		ncls  = cls_q;
		if (pos_q < drbd_pkg::POS_W'(drbd_pkg::OBJ_POS)) begin
			nbox[pos_q[1:0]] = row_value;
		end else if (pos_q == drbd_pkg::POS_W'(drbd_pkg::OBJ_POS)) begin
			nobj = row_value;
		end else if ({1'b0, pos_q} < CLS_END && row_value > best_q) begin
			nbest = row_value;
			ncls  = pos_q - drbd_pkg::POS_W'(drbd_pkg::FIRST_CLASS_POS);
		end
	end

	assign job.cx   = nbox[0];
	assign job.cy   = nbox[1];
	assign job.w    = nbox[2];
	assign job.h    = nbox[3];
	assign job.obj  = nobj;
	assign job.best = nbest;
	assign job.cls  = ncls;

	always_ff @(posedge clk) begin
		if (accept) begin
			box_q <= nbox;
			obj_q <= nobj;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			best_q <= '0;
			cls_q  <= '0;
		end else if (accept) begin
			if (row_end) begin
				pos_q  <= '0;
				best_q <= '0;
				cls_q  <= '0;
			end else begin
				if (pos_q != drbd_pkg::POS_W'(drbd_pkg::POS_MAX))
					pos_q <= pos_q + 1'b1;
				best_q <= nbest;
				cls_q  <= ncls;
			end
		end
	end

endmodule

// File: sv/drbd_queue.sv
// Two-entry queue of finished rows between the front end and the box sequencer.
// Depends on drbd_pkg.
`timescale 1ns / 1ps

module drbd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  drbd_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output drbd_pkg::job_t pop_job,
	output logic           empty
);

	drbd_pkg::job_t mem [drbd_pkg::Q_DEPTH];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign full    = count_q == 2'(drbd_pkg::Q_DEPTH);
	assign empty   = count_q == 2'd0;
	assign pop_job = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue written while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue read while empty");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 2'd1)
		else $error("queue count lost a transfer");

endmodule

// File: sv/drbd_back.sv
// Box sequencer: score check (own multiplier), letterbox undo and clamping over several steps
// through one constant multiplier and one scale multiplier. Depends on drbd_pkg.
`timescale 1ns / 1ps

module drbd_back #(
	parameter int NETWORK_SIZE = 640
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  drbd_pkg::cfg_t                     cfg,
	input  logic                               q_empty,
	input  drbd_pkg::job_t                     q_job,
	output logic                               q_pop,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [drbd_pkg::OUT_TDATA_W-1:0]   m_tdata
);

	localparam int NS_W = $clog2(NETWORK_SIZE + 1);
	localparam int T_W  = ((17 + NS_W > 27) ? 17 + NS_W : 27) + 2;
	localparam int P_W  = T_W - 1 + drbd_pkg::INV_W;
	localparam logic signed [T_W-1:0] NS_T = T_W'(NETWORK_SIZE);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCORE,
		ST_NX,
		ST_LX,
		ST_NY,
		ST_TY,
		ST_WN,
		ST_EW,
		ST_HN,
		ST_EH,
		ST_CLAMP
	} state_t;

	state_t                      state_q;
	logic                        m_valid_q;
	drbd_pkg::result_t           m_data_q;

	drbd_pkg::job_t              job_q;
	logic signed [T_W-1:0]       t_q;
	logic [12:0]                 left_q;
	logic [12:0]                 top_q;
	logic [12:0]                 ew_q;
	logic [12:0]                 eh_q;
	logic [drbd_pkg::VAL_W-1:0]  score_q;

	logic signed [18:0]          dx;
	logic signed [18:0]          dy;
	logic signed [T_W-1:0]       c_a;
	logic [drbd_pkg::PAD_W-1:0]  c_pad;
	logic signed [T_W-1:0]       pad_term;
	logic signed [T_W-1:0]       cprod;
	logic [P_W-1:0]              m;
	logic [P_W-1:0]              sh;
	logic [12:0]                 sat;
	logic                        is_edge;
	logic                        t_pos;
	logic [12:0]                 mval;
	logic [31:0]                 sprod;
	logic                        pass;
	logic                        out_free;
	drbd_pkg::axis_t             ax;
	drbd_pkg::axis_t             ay;
	drbd_pkg::result_t           res;

	// 2*center - extent, in signed Q2.16
	assign dx = $signed({2'b00, job_q.cx, 1'b0}) - $signed({3'b000, job_q.w});
	assign dy = $signed({2'b00, job_q.cy, 1'b0}) - $signed({3'b000, job_q.h});

	always_comb begin
		case (state_q)
			ST_NX: begin
				c_a   = T_W'(dx);
				c_pad = cfg.pad_left;
			end
			ST_NY: begin
				c_a   = T_W'(dy);
				c_pad = cfg.pad_top;
			end
			ST_HN: begin
				c_a   = $signed({{(T_W-drbd_pkg::VAL_W){1'b0}}, job_q.h});
				c_pad = '0;
			end
			default: begin
				c_a   = $signed({{(T_W-drbd_pkg::VAL_W){1'b0}}, job_q.w});
				c_pad = '0;
			end
		endcase
	end

	// edge numerator in units of 2^-17 network pixels, extent in 2^-16
	assign pad_term = $signed({{(T_W-drbd_pkg::PAD_W-17){1'b0}}, c_pad, 17'b0});
	assign cprod    = c_a * NS_T - pad_term;

	assign m       = P_W'(t_q[T_W-2:0]) * P_W'(cfg.inv_scale);
	assign is_edge = (state_q == ST_LX) || (state_q == ST_TY);
	assign sh      = is_edge ? (m >> 33) : (m >> 32);
	assign sat     = (|sh[P_W-1:13]) ? 13'h1FFF : sh[12:0];
	assign t_pos   = !t_q[T_W-1] && (|t_q);
	assign mval    = (is_edge && !t_pos) ? 13'd0 : sat;

	assign sprod = 32'(job_q.obj) * 32'(job_q.best);
	assign pass  = (job_q.obj > cfg.threshold) && (sprod[31:16] > cfg.threshold);

	assign ax = drbd_pkg::clamp_axis(left_q, ew_q, drbd_pkg::dim_of(cfg.img_w));
	assign ay = drbd_pkg::clamp_axis(top_q, eh_q, drbd_pkg::dim_of(cfg.img_h));

	always_comb begin
		res.score  = score_q;
		res.cls    = job_q.cls;
		res.height = ay.ext;
		res.width  = ax.ext;
		res.top    = ay.pos;
		res.left   = ax.pos;
	end

	assign out_free = !m_valid_q || m_tready;
	assign q_pop    = (state_q == ST_IDLE) && !q_empty;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(drbd_pkg::OUT_TDATA_W-$bits(drbd_pkg::result_t)){1'b0}}, m_data_q};

	always_ff @(posedge clk) begin
		if (q_pop)
			job_q <= q_job;
		case (state_q)
			ST_SCORE: score_q <= sprod[31:16];
			ST_NX, ST_NY, ST_WN, ST_HN: t_q <= cprod;
			ST_LX: left_q <= mval;
			ST_TY: top_q <= mval;
			ST_EW: ew_q <= mval;
			ST_EH: eh_q <= mval;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
		end else begin
			if (state_q == ST_CLAMP && out_free)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE:  if (!q_empty) state_q <= ST_SCORE;
				ST_SCORE: state_q <= pass ? ST_NX : ST_IDLE;
				ST_NX:    state_q <= ST_LX;
				ST_LX:    state_q <= ST_NY;
				ST_NY:    state_q <= ST_TY;
				ST_TY:    state_q <= ST_WN;
				ST_WN:    state_q <= ST_EW;
				ST_EW:    state_q <= ST_HN;
				ST_HN:    state_q <= ST_EH;
				ST_EH:    state_q <= ST_CLAMP;
				ST_CLAMP: begin
					if (out_free) begin
						m_data_q <= res;
						state_q  <= ST_IDLE;
					end
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	a_pop_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && !q_empty) |=> state_q == ST_SCORE)
		else $error("queued row not started");
	a_drop_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCORE && !pass) |=> state_q == ST_IDLE)
		else $error("rejected row not dropped");
	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLAMP && out_free) |=> m_valid_q)
		else $error("finished box not presented");

endmodule

// File: sv/detection_row_box_decode_top.sv
// Top level of the detection row box decoder: configuration registers and the
// front end, row queue and box sequencer. Depends on drbd_pkg and the drbd_ modules.
`timescale 1ns / 1ps

// Row values stream in one per cycle on the s_ side while s_tready is high, tlast
// marking a row's last value: center x, center y, width, height, objectness, then
// NUM_CLASSES scores. A row that passes the threshold yields one clamped box on the
// m_ side. Rows go to a two-entry queue; the box sequencer drops a failing row after
// its score check and steps a passing one to its clamp, waiting out an output stall,
// so s_tready drops only while both queue entries are waiting. Configuration writes
// are always accepted (cfg_ready is tied high) and take effect next cycle.

module detection_row_box_decode_top #(
	parameter int NUM_CLASSES  = 80,
	parameter int NETWORK_SIZE = 640
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [15:0]                         s_tdata,   // [15:0] row_value
	input  logic                                s_tlast,   // row_end
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [11:0] box_left, [23:12] box_top, [36:24] box_width, [49:37] box_height,
	// [56:50] class_index, [72:57] box_score, [79:73] zero
	output logic [drbd_pkg::OUT_TDATA_W-1:0]    m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [drbd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [drbd_pkg::CFG_DATA_W-1:0]     cfg_data
);

	drbd_pkg::cfg_t cfg_q;
	drbd_pkg::job_t push_job;
	drbd_pkg::job_t pop_job;
	logic           push;
	logic           pop;
	logic           q_full;
	logic           q_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold <= 16'd16384;
			cfg_q.inv_scale <= 20'd131072;
			cfg_q.pad_left  <= 10'd0;
			cfg_q.pad_top   <= 10'd140;
			cfg_q.img_w     <= 13'd1280;
			cfg_q.img_h     <= 13'd720;
		end else if (cfg_valid && cfg_ready) begin
			case (drbd_pkg::cfg_idx_t'(cfg_index))
				drbd_pkg::CFG_THRESHOLD: cfg_q.threshold <= cfg_data[15:0];
				drbd_pkg::CFG_INV_SCALE: cfg_q.inv_scale <= cfg_data;
				drbd_pkg::CFG_PAD_LEFT:  cfg_q.pad_left  <= cfg_data[9:0];
				drbd_pkg::CFG_PAD_TOP:   cfg_q.pad_top   <= cfg_data[9:0];
				drbd_pkg::CFG_IMG_W:     cfg_q.img_w     <= cfg_data[12:0];
				drbd_pkg::CFG_IMG_H:     cfg_q.img_h     <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	drbd_front #(
		.NUM_CLASSES (NUM_CLASSES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.row_value (s_tdata),
		.row_end   (s_tlast),
		.q_full    (q_full),
		.push      (push),
		.job       (push_job)
	);

	drbd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.pop_job  (pop_job),
		.empty    (q_empty)
	);

	drbd_back #(
		.NETWORK_SIZE (NETWORK_SIZE)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.q_job    (pop_job),
		.q_pop    (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for detection_row_box_decode_top: streams detection rows,
// predicts each clamped box in a scoreboard class and checks every output transfer.
// Depends on drbd_pkg and the detection_row_box_decode_top RTL.
`timescale 1ns / 1ps

localparam int NET_SIZE = 640;
localparam int NUM_CLS  = 80;

class box_scoreboard;
	bit [15:0] threshold;
	bit [19:0] inv_scale;
	bit [9:0]  pad_l;
	bit [9:0]  pad_t;
	bit [12:0] img_w;
	bit [12:0] img_h;
	bit [6:0]  pos;
	bit [15:0] box_vals [drbd_pkg::BOX_SLOTS];
	bit [15:0] obj;
	bit [15:0] best;
	bit [6:0]  best_cls;
	drbd_pkg::result_t boxes_due [$];
	int        errors;

	function new();
		threshold = 16'd16384;
		inv_scale = 20'd131072;
		pad_l = 10'd0;
		pad_t = 10'd140;
		img_w = 13'd1280;
		img_h = 13'd720;
		pos = '0;
		foreach (box_vals[i]) box_vals[i] = '0;
		obj = '0;
		best = '0;
		best_cls = '0;
		errors = 0;
	endfunction

	function void set_reg(drbd_pkg::cfg_idx_t idx, bit [19:0] d);
		case (idx)
			drbd_pkg::CFG_THRESHOLD: threshold = d[15:0];
			drbd_pkg::CFG_INV_SCALE: inv_scale = d;
			drbd_pkg::CFG_PAD_LEFT:  pad_l = d[9:0];
			drbd_pkg::CFG_PAD_TOP:   pad_t = d[9:0];
			drbd_pkg::CFG_IMG_W:     img_w = d[12:0];
			drbd_pkg::CFG_IMG_H:     img_h = d[12:0];
			default: ;
		endcase
	endfunction

	function longint dim(bit [12:0] d);
		if (d == 0)
			return 1;
		if (d > drbd_pkg::IMG_MAX)
			return drbd_pkg::IMG_MAX;
		return longint'(d);
	endfunction

	// leading edge in image pixels; the sum is kept in units of 2^-17 pixel
	function longint lead_edge(bit [15:0] c, bit [15:0] e, bit [9:0] pad);
		longint n;
		n = (2 * longint'(c) - longint'(e)) * NET_SIZE - (longint'(pad) << 17);
		if (n <= 0)
			return 0;
		return (n * longint'(inv_scale)) >>> 33;
	endfunction

	function longint box_extent(bit [15:0] e);
		return (longint'(e) * NET_SIZE * longint'(inv_scale)) >>> 32;
	endfunction

	function void fit_axis(longint at, longint span, longint lim,
		output bit [11:0] o_at, output bit [12:0] o_span);
		longint w1;
		longint p;
		w1 = (span < lim - at) ? span : lim - at;
		p = (at < lim - 1) ? at : lim - 1;
		if (w1 < 0)
			w1 = 0;
		if (w1 > lim - p)
			w1 = lim - p;
		o_at = 12'(p);
		o_span = 13'(w1);
	endfunction

	function void take_row_value(bit [15:0] v, bit row_last);
		drbd_pkg::result_t b;
		bit [15:0] score;
		bit [11:0] at;
		bit [12:0] span;
		if (pos < drbd_pkg::OBJ_POS) begin
			box_vals[pos] = v;
		end else if (pos == drbd_pkg::OBJ_POS) begin
			obj = v;
		end else if (pos < drbd_pkg::FIRST_CLASS_POS + NUM_CLS && v > best) begin
			best = v;
			best_cls = 7'(pos - drbd_pkg::FIRST_CLASS_POS);
		end
		if (pos < drbd_pkg::POS_MAX)
			pos++;
		if (row_last) begin
			score = 16'((32'(obj) * 32'(best)) >> 16);
			if (obj > threshold && score > threshold) begin
				b = '0;
				fit_axis(lead_edge(box_vals[0], box_vals[2], pad_l), box_extent(box_vals[2]),
					dim(img_w), at, span);
				b.left = at;
				b.width = span;
				fit_axis(lead_edge(box_vals[1], box_vals[3], pad_t), box_extent(box_vals[3]),
					dim(img_h), at, span);
				b.top = at;
				b.height = span;
				b.cls = best_cls;
				b.score = score;
				boxes_due = {boxes_due, b};
			end
			pos = '0;
			best = '0;
			best_cls = '0;
		end
	endfunction

	function void cmp_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	function void check_box(bit [drbd_pkg::OUT_TDATA_W-1:0] d);
		drbd_pkg::result_t got;
		drbd_pkg::result_t want;
		got = drbd_pkg::result_t'(d[$bits(drbd_pkg::result_t)-1:0]);
		if (boxes_due.size() == 0) begin
			$error("box_left: expected no box, got %0d", got.left);
			errors++;
			return;
		end
		want = boxes_due.pop_front();
		cmp_field("box_left", want.left, got.left);
		cmp_field("box_top", want.top, got.top);
		cmp_field("box_width", want.width, got.width);
		cmp_field("box_height", want.height, got.height);
		cmp_field("class_index", want.cls, got.cls);
		cmp_field("box_score", want.score, got.score);
	endfunction
endclass

module testbench;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	logic [15:0]                      s_tdata = '0;
	logic                             s_tlast = 1'b0;
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic [drbd_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [drbd_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
	logic [drbd_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

	box_scoreboard sb = new();
	bit            bursty = 1'b1;
	int            items = 0;

	detection_row_box_decode_top #(
		.NUM_CLASSES(NUM_CLS),
		.NETWORK_SIZE(NET_SIZE)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		m_tready <= !bursty || ($urandom_range(0, 99) >= 6);
	end

	// transfers are seen with pre-edge values of both sides
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.take_row_value(s_tdata, s_tlast);
			if (m_tvalid && m_tready)
				sb.check_box(m_tdata);
			if (cfg_valid && cfg_ready)
				sb.set_reg(drbd_pkg::cfg_idx_t'(cfg_index), cfg_data);
		end
	end

	initial begin
		#1000000;
		$display("detection_row_box_decode_top test failed");
		$finish;
	end

	task automatic push_value(input bit [15:0] v, input bit row_last);
		while (bursty && $urandom_range(0, 99) < 6) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= v;
		s_tlast <= row_last;
		do @(posedge clk); while (!s_tready);
		items++;
	endtask

	task automatic push_row(input bit [15:0] vals [$]);
		foreach (vals[i])
			push_value(vals[i], i == vals.size() - 1);
	endtask

	// rows without a box may still be in the sequencer after the last box
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.boxes_due.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// valid stays high across the six writes
	task automatic write_reg(input drbd_pkg::cfg_idx_t idx, input bit [19:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic apply_settings(input bit [15:0] thr, input bit [19:0] inv,
		input bit [9:0] pl, input bit [9:0] pt, input bit [12:0] iw, input bit [12:0] ih);
		write_reg(drbd_pkg::CFG_THRESHOLD, 20'(thr));
		write_reg(drbd_pkg::CFG_INV_SCALE, inv);
		write_reg(drbd_pkg::CFG_PAD_LEFT, 20'(pl));
		write_reg(drbd_pkg::CFG_PAD_TOP, 20'(pt));
		write_reg(drbd_pkg::CFG_IMG_W, 20'(iw));
		write_reg(drbd_pkg::CFG_IMG_H, 20'(ih));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// keen rows carry strong objectness and some strong class scores
	task automatic send_row(input int n, input bit keen);
		bit [15:0] v;
		bit [15:0] prev;
		prev = '0;
		for (int i = 0; i < n; i++) begin
			if (i < drbd_pkg::OBJ_POS)
				v = (i >= 2 && $urandom_range(0, 1)) ? 16'($urandom_range(0, 16384))
					: 16'($urandom);
			else if (i == drbd_pkg::OBJ_POS)
				v = keen ? 16'($urandom_range(sb.threshold, 65535)) : 16'($urandom);
			else if ($urandom_range(0, 9) == 0)
				v = prev;
			else if (keen && $urandom_range(0, 3) == 0)
				v = 16'($urandom_range(60000, 65535));
			else
				v = 16'($urandom);
			prev = v;
			push_value(v, i == n - 1);
		end
	endtask

	initial begin
		int phase;
		int phase_start;
		int r;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first row reaches objectness so it is written before any short row reads it;
		// tied best scores keep the first class
		push_row('{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF});
		// objectness equal to the threshold
		push_row('{16'h8000, 16'h8000, 16'h1000, 16'h1000, 16'h4000, 16'hFFFF});
		// short row reusing earlier box values
		push_row('{16'h1234, 16'h0001});
		// row ending on objectness, no class score
		push_row('{16'h7FFF, 16'h8000, 16'h2000, 16'h3000, 16'hFFFF});
		// combined score equal to the threshold
		push_row('{16'h4000, 16'hC000, 16'h8000, 16'h0100, 16'hFFFF, 16'h0000, 16'h4001});
		drain();

		phase = 1;
		while (items < 1550 && phase <= 40) begin
			bursty = !(phase == 3 || phase == 6);
			case (phase)
				1: apply_settings(16'd0, 20'hFFFFF, 10'd0, 10'd0, 13'd4096, 13'd4096);
				2: apply_settings(16'hFFFF, 20'd0, 10'h3FF, 10'h3FF, 13'd1, 13'd1);
				3: apply_settings(16'd1, 20'd65536, 10'd640, 10'd0, 13'd0, 13'h1FFF);
				4: apply_settings(16'd30000, 20'($urandom_range(0, 20'hFFFFF)),
					10'($urandom), 10'($urandom), 13'h1FFF, 13'd0);
				default: apply_settings(16'($urandom_range(0, 40000)),
					($urandom_range(0, 3) != 0) ? 20'($urandom_range(30000, 200000))
						: 20'($urandom),
					($urandom_range(0, 7) != 0) ? 10'($urandom_range(0, 640)) : 10'($urandom),
					($urandom_range(0, 7) != 0) ? 10'($urandom_range(0, 640)) : 10'($urandom),
					($urandom_range(0, 7) != 0) ? 13'($urandom_range(1, 4096)) : 13'($urandom),
					($urandom_range(0, 7) != 0) ? 13'($urandom_range(1, 4096)) : 13'($urandom));
			endcase
			phase_start = items;
			while (items - phase_start < 160) begin
				r = $urandom_range(0, 99);
				if (r < 70)
					send_row(drbd_pkg::FIRST_CLASS_POS + $urandom_range(1, 12), 1'b1);
				else if (r < 80)
					send_row(drbd_pkg::FIRST_CLASS_POS + NUM_CLS, 1'b1);
				else if (r < 85)
					send_row($urandom_range(drbd_pkg::FIRST_CLASS_POS + NUM_CLS + 1, 140), 1'b1);
				else if (r < 92)
					send_row($urandom_range(1, drbd_pkg::FIRST_CLASS_POS), 1'b0);
				else
					send_row(drbd_pkg::FIRST_CLASS_POS + $urandom_range(1, 20), 1'b0);
			end
			drain();
			phase++;
		end

		if (sb.errors == 0 && sb.boxes_due.size() == 0)
			$display("detection_row_box_decode_top test passed");
		else
			$display("detection_row_box_decode_top test failed");
		$finish;
	end

endmodule

// File: sim.f
sv/drbd_pkg.sv
sv/drbd_front.sv
sv/drbd_queue.sv
sv/drbd_back.sv
sv/detection_row_box_decode_top.sv
tb/sv/testbench.sv
